### rtl/slfrd_pkg.sv
// Shared constants and types for the sync/length framed receiver and decoder.
// No dependencies.
package slfrd_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned LEN_W  = 9;
  localparam int unsigned POS_W  = 5;

  localparam logic [BYTE_W-1:0] SYNC_FIRST  = 8'h55;
  localparam logic [BYTE_W-1:0] SYNC_SECOND = 8'hAA;
  localparam logic [BYTE_W-1:0] FRAME_ID    = 8'h38;
  localparam logic [BYTE_W-1:0] MOD_ANALOG  = 8'h07;
  localparam logic [BYTE_W-1:0] METH_LOW    = 8'h60;
  localparam logic [BYTE_W-1:0] METH_HIGH   = 8'h61;
  localparam logic [BYTE_W-1:0] MOD_MOTOR   = 8'h08;

  localparam logic [LEN_W-1:0] LEN_EXTRA = 9'd8;
  localparam logic [LEN_W-1:0] LEN_RESET = 9'd2;

  // Fixed byte positions within a frame
  localparam logic [POS_W-1:0] POS_SYNC0 = 5'd0;
  localparam logic [POS_W-1:0] POS_SYNC1 = 5'd1;
  localparam logic [POS_W-1:0] POS_ID    = 5'd2;
  localparam logic [POS_W-1:0] POS_LEN   = 5'd3;
  localparam logic [POS_W-1:0] POS_MOD   = 5'd4;
  localparam logic [POS_W-1:0] POS_METH  = 5'd5;
  localparam logic [POS_W-1:0] POS_DATA  = 5'd7;

  typedef enum logic [1:0] {
    KIND_ANALOG = 2'd0,
    KIND_MOTOR  = 2'd1,
    KIND_OTHER  = 2'd2
  } kind_e;

endpackage

### rtl/slfrd_store.sv
// Frame byte store: one write port, one registered read port.
// Per-entry valid bits make unwritten entries read as zero after reset.
// Depends on slfrd_pkg.
module slfrd_store import slfrd_pkg::*; #(
  parameter int unsigned DEPTH = 128,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_en_i,
  input  logic [AW-1:0]     wr_addr_i,
  input  logic [BYTE_W-1:0] wr_data_i,
  input  logic [AW-1:0]     rd_addr_i,
  output logic [BYTE_W-1:0] rd_data_o
);

  logic [BYTE_W-1:0] mem_q [DEPTH];
  logic [DEPTH-1:0]  vld_q;
  logic [BYTE_W-1:0] rd_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_en_i) begin
      vld_q[wr_addr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= vld_q[rd_addr_i] ? mem_q[rd_addr_i] : '0;
  end

  assign rd_data_o = rd_data_q;

endmodule

### rtl/sync_length_frame_receiver_decoder_top.sv
// Sync/length framed packet receiver and decoder, top level.
// An ordinary byte is accepted without a stall; a sync pair's second byte stalls input for
// the fixed-slot sync byte writes. A completing byte holds input for the decode: header reads,
// a read and a capture per data byte, and an emit per result, which waits on output stall.
// The single-port store read sets the decode time. Reset is asynchronous; control clears
// at once and the store reads zero through per-entry valid bits, no clearing pass.
// Depends on slfrd_pkg, slfrd_store.
module sync_length_frame_receiver_decoder_top import slfrd_pkg::*; #(
  parameter int unsigned BUFFER_BYTES = 128
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         rx_byte_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         kind_o,
  output logic [3:0]         item_index_o,
  output logic [15:0]        analog_value_o,
  output logic signed [31:0] motor_position_o,
  output logic signed [15:0] motor_current_o,
  output logic               last_o
);

  localparam int unsigned AW    = $clog2(BUFFER_BYTES);
  localparam int unsigned WIW   = $clog2(BUFFER_BYTES + 1);
  localparam int unsigned ACC_W = 6 * BYTE_W;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SYNC0 = 4'd1;
  localparam logic [3:0] S_SYNC1 = 4'd2;
  localparam logic [3:0] S_HID   = 4'd3;
  localparam logic [3:0] S_HMOD  = 4'd4;
  localparam logic [3:0] S_HMET  = 4'd5;
  localparam logic [3:0] S_HDEC  = 4'd6;
  localparam logic [3:0] S_RD    = 4'd7;
  localparam logic [3:0] S_CAP   = 4'd8;
  localparam logic [3:0] S_EMIT  = 4'd9;

  localparam logic [2:0] ANALOG_LAST_BYTE = 3'd1;
  localparam logic [2:0] MOTOR_LAST_BYTE  = 3'd5;
  localparam logic [2:0] ANALOG_LAST_ITEM = 3'd7;
  localparam logic [2:0] MOTOR_LAST_ITEM  = 3'd3;

  logic [3:0]        state_q, state_d;
  logic [BYTE_W-1:0] prev_q, prev_d;
  logic              in_frame_q, in_frame_d;
  logic [WIW-1:0]    wi_q, wi_d;
  logic [LEN_W-1:0]  len_q, len_d;

  logic              id_ok_q, id_ok_d;
  logic [BYTE_W-1:0] mod_q, mod_d;
  kind_e             mode_q, mode_d;
  logic              base_q, base_d;
  logic [POS_W-1:0]  rp_q, rp_d;
  logic [2:0]        bcnt_q, bcnt_d;
  logic [2:0]        item_q, item_d;
  logic [ACC_W-1:0]  acc_q, acc_d;

  logic              out_valid_q, out_valid_d;
  kind_e             out_kind_q, out_kind_d;
  logic [3:0]        out_idx_q, out_idx_d;
  logic [15:0]       out_aval_q, out_aval_d;
  logic [31:0]       out_pos_q, out_pos_d;
  logic [15:0]       out_cur_q, out_cur_d;
  logic              out_last_q, out_last_d;

  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [BYTE_W-1:0] wr_data;
  logic [AW-1:0]     rd_addr;
  logic [BYTE_W-1:0] rd_data;

  logic              in_acc, out_free, in_room, sync_hit;
  logic [WIW-1:0]    wi_inc;
  logic [2:0]        last_byte, last_item;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_room    = (wi_q < WIW'(BUFFER_BYTES));
  assign sync_hit   = (prev_q == SYNC_FIRST) && (rx_byte_i == SYNC_SECOND) && !in_frame_q;
  assign wi_inc     = wi_q + WIW'(1);
  assign last_byte  = (mode_q == KIND_MOTOR) ? MOTOR_LAST_BYTE : ANALOG_LAST_BYTE;
  assign last_item  = (mode_q == KIND_MOTOR) ? MOTOR_LAST_ITEM : ANALOG_LAST_ITEM;

  // Store write port: shadow write of accepted bytes with room, sync bytes after a pair
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = wi_q[AW-1:0];
    wr_data = rx_byte_i;
    case (state_q)
      S_IDLE: begin
        wr_en = in_acc && in_room;
      end
      S_SYNC0: begin
        wr_en   = 1'b1;
        wr_addr = AW'(POS_SYNC0);
        wr_data = SYNC_FIRST;
      end
      S_SYNC1: begin
        wr_en   = 1'b1;
        wr_addr = AW'(POS_SYNC1);
        wr_data = SYNC_SECOND;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_comb begin
    case (state_q)
      S_HID:   rd_addr = AW'(POS_ID);
      S_HMOD:  rd_addr = AW'(POS_MOD);
      S_HMET:  rd_addr = AW'(POS_METH);
      default: rd_addr = AW'(rp_q);
    endcase
  end

  slfrd_store #(
    .DEPTH (BUFFER_BYTES)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  always_comb begin
    state_d     = state_q;
    prev_d      = prev_q;
    in_frame_d  = in_frame_q;
    wi_d        = wi_q;
    len_d       = len_q;
    id_ok_d     = id_ok_q;
    mod_d       = mod_q;
    mode_d      = mode_q;
    base_d      = base_q;
    rp_d        = rp_q;
    bcnt_d      = bcnt_q;
    item_d      = item_q;
    acc_d       = acc_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_kind_d  = out_kind_q;
    out_idx_d   = out_idx_q;
    out_aval_d  = out_aval_q;
    out_pos_d   = out_pos_q;
    out_cur_d   = out_cur_q;
    out_last_d  = out_last_q;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (sync_hit) begin
            in_frame_d = 1'b1;
            wi_d       = WIW'(POS_ID);
            prev_d     = '0;
            state_d    = S_SYNC0;
          end else if (in_frame_q) begin
            if (wi_q == WIW'(POS_LEN)) begin
              len_d = LEN_W'(rx_byte_i) + LEN_EXTRA;
            end
            wi_d = wi_inc;
            if (LEN_W'(wi_inc) == ((wi_q == WIW'(POS_LEN)) ?
                                   (LEN_W'(rx_byte_i) + LEN_EXTRA) : len_q)) begin
              in_frame_d = 1'b0;
              state_d    = S_HID;
            end
            if (wi_inc >= WIW'(BUFFER_BYTES)) begin
              in_frame_d = 1'b0;
            end
          end else begin
            prev_d = rx_byte_i;
          end
        end
      end
      S_SYNC0: state_d = S_SYNC1;
      S_SYNC1: state_d = S_IDLE;
      S_HID:   state_d = S_HMOD;
      S_HMOD: begin
        id_ok_d = (rd_data == FRAME_ID);
        state_d = S_HMET;
      end
      S_HMET: begin
        mod_d   = rd_data;
        state_d = S_HDEC;
      end
      S_HDEC: begin
        rp_d   = POS_DATA;
        bcnt_d = '0;
        item_d = '0;
        base_d = (rd_data == METH_HIGH);
        if (id_ok_q && mod_q == MOD_ANALOG &&
            (rd_data == METH_LOW || rd_data == METH_HIGH)) begin
          mode_d  = KIND_ANALOG;
          state_d = S_RD;
        end else if (id_ok_q && mod_q == MOD_MOTOR) begin
          mode_d  = KIND_MOTOR;
          state_d = S_RD;
        end else begin
          mode_d  = KIND_OTHER;
          state_d = S_EMIT;
        end
      end
      S_RD: state_d = S_CAP;
      S_CAP: begin
        acc_d = {acc_q[ACC_W-BYTE_W-1:0], rd_data};
        rp_d  = rp_q + POS_W'(1);
        if (bcnt_q == last_byte) begin
          bcnt_d  = '0;
          state_d = S_EMIT;
        end else begin
          bcnt_d  = bcnt_q + 3'd1;
          state_d = S_RD;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_kind_d  = mode_q;
          out_idx_d   = '0;
          out_aval_d  = '0;
          out_pos_d   = '0;
          out_cur_d   = '0;
          out_last_d  = 1'b1;
          case (mode_q)
            KIND_ANALOG: begin
              out_idx_d  = {base_q, item_q};
              out_aval_d = acc_q[15:0];
              out_last_d = (item_q == last_item);
            end
            KIND_MOTOR: begin
              out_idx_d  = {1'b0, item_q};
              out_pos_d  = acc_q[47:16];
              out_cur_d  = acc_q[15:0];
              out_last_d = (item_q == last_item);
            end
            default: begin
              out_last_d = 1'b1;
            end
          endcase
          if (mode_q == KIND_OTHER || item_q == last_item) begin
            state_d = S_IDLE;
          end else begin
            item_d  = item_q + 3'd1;
            state_d = S_RD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      prev_q      <= '0;
      in_frame_q  <= 1'b0;
      wi_q        <= '0;
      len_q       <= LEN_RESET;
      mode_q      <= KIND_OTHER;
      rp_q        <= '0;
      bcnt_q      <= '0;
      item_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      prev_q      <= prev_d;
      in_frame_q  <= in_frame_d;
      wi_q        <= wi_d;
      len_q       <= len_d;
      mode_q      <= mode_d;
      rp_q        <= rp_d;
      bcnt_q      <= bcnt_d;
      item_q      <= item_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_ok_q    <= id_ok_d;
    mod_q      <= mod_d;
    base_q     <= base_d;
    acc_q      <= acc_d;
    out_kind_q <= out_kind_d;
    out_idx_q  <= out_idx_d;
    out_aval_q <= out_aval_d;
    out_pos_q  <= out_pos_d;
    out_cur_q  <= out_cur_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o      = out_valid_q;
  assign kind_o           = out_kind_q;
  assign item_index_o     = out_idx_q;
  assign analog_value_o   = out_aval_q;
  assign motor_position_o = out_pos_q;
  assign motor_current_o  = out_cur_q;
  assign last_o           = out_last_q;

endmodule

### bench/sync_length_frame_receiver_decoder_checker.sv
// Checker for sync_length_frame_receiver_decoder_top: tracks the frame store and the decoder
// on every input transaction and compares each output transaction with the oldest prediction.
// Depends on slfrd_pkg.
`timescale 1ns / 1ps
module sync_length_frame_receiver_decoder_checker import slfrd_pkg::*; #(
  parameter int unsigned BUFFER_BYTES = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [1:0]  kind_i,
  input  logic [3:0]  item_index_i,
  input  logic [15:0] analog_value_i,
  input  logic [31:0] motor_position_i,
  input  logic [15:0] motor_current_i,
  input  logic        last_i,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    kind_e       kind;
    logic [3:0]  item_index;
    logic [15:0] analog_value;
    logic [31:0] motor_position;
    logic [15:0] motor_current;
    logic        last;
  } decode_rec_t;

  decode_rec_t pending_decodes[$];

  logic [7:0]  rx_mem [BUFFER_BYTES];
  logic [7:0]  prev_byte;
  logic        in_frame;
  int unsigned wr_idx;
  int unsigned frame_len;
  int          fail_count = 0;

  function automatic logic [7:0] byte_at(input int unsigned pos);
    return (pos < BUFFER_BYTES) ? rx_mem[pos] : 8'h00;
  endfunction

  task automatic push_rec(input kind_e k, input int unsigned idx, input logic [15:0] av,
                          input logic [31:0] p, input logic [15:0] c, input logic l);
    decode_rec_t r;
    r.kind           = k;
    r.item_index     = 4'(idx);
    r.analog_value   = av;
    r.motor_position = p;
    r.motor_current  = c;
    r.last           = l;
    pending_decodes.push_back(r);
  endtask

  task automatic decode_frame();
    int unsigned i;
    int unsigned base;
    int unsigned p;
    logic        id_ok;
    logic [7:0]  mod_b;
    logic [7:0]  meth_b;
    id_ok  = (byte_at(POS_ID) == FRAME_ID);
    mod_b  = byte_at(POS_MOD);
    meth_b = byte_at(POS_METH);
    if (id_ok && mod_b == MOD_ANALOG && (meth_b == METH_LOW || meth_b == METH_HIGH)) begin
      base = (meth_b == METH_HIGH) ? 8 : 0;
      for (i = 0; i < 8; i++) begin
        push_rec(KIND_ANALOG, base + i,
                 {byte_at(POS_DATA + 2 * i), byte_at(POS_DATA + 2 * i + 1)},
                 '0, '0, i == 7);
      end
    end else if (id_ok && mod_b == MOD_MOTOR) begin
      for (i = 0; i < 4; i++) begin
        p = POS_DATA + 6 * i;
        push_rec(KIND_MOTOR, i, '0,
                 {byte_at(p), byte_at(p + 1), byte_at(p + 2), byte_at(p + 3)},
                 {byte_at(p + 4), byte_at(p + 5)}, i == 3);
      end
    end else begin
      push_rec(KIND_OTHER, 0, '0, '0, '0, 1'b1);
    end
  endtask

  // One received byte; the store is written at the current index even outside a frame.
  task automatic absorb_byte(input logic [7:0] b);
    if (wr_idx < BUFFER_BYTES) rx_mem[wr_idx] = b;
    if (prev_byte == SYNC_FIRST && b == SYNC_SECOND && !in_frame) begin
      in_frame        = 1'b1;
      rx_mem[POS_SYNC0] = SYNC_FIRST;
      rx_mem[POS_SYNC1] = SYNC_SECOND;
      wr_idx          = 2;
      prev_byte       = '0;
    end else if (in_frame) begin
      // length is stale until the length byte itself lands
      if (wr_idx == POS_LEN) frame_len = b + LEN_EXTRA;
      wr_idx++;
      if (wr_idx == frame_len) begin
        decode_frame();
        in_frame = 1'b0;
      end
      if (wr_idx >= BUFFER_BYTES) in_frame = 1'b0;
    end else begin
      prev_byte = b;
    end
  endtask

  task automatic check_result();
    decode_rec_t got;
    decode_rec_t want;
    got.kind           = kind_e'(kind_i);
    got.item_index     = item_index_i;
    got.analog_value   = analog_value_i;
    got.motor_position = motor_position_i;
    got.motor_current  = motor_current_i;
    got.last           = last_i;
    if (pending_decodes.size() == 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("%0t: unexpected result kind %0d idx %0d ana %h pos %h cur %h last %b",
                 $realtime, got.kind, got.item_index, got.analog_value,
                 got.motor_position, got.motor_current, got.last);
    end else begin
      want = pending_decodes.pop_front();
      if (got !== want) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("%0t: expected kind %0d idx %0d ana %h pos %h cur %h last %b",
                   $realtime, want.kind, want.item_index, want.analog_value,
                   want.motor_position, want.motor_current, want.last);
          $display("%0t: actual   kind %0d idx %0d ana %h pos %h cur %h last %b",
                   $realtime, got.kind, got.item_index, got.analog_value,
                   got.motor_position, got.motor_current, got.last);
        end
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      prev_byte = '0;
      in_frame  = 1'b0;
      wr_idx    = 0;
      frame_len = LEN_RESET;
      foreach (rx_mem[k]) rx_mem[k] = '0;
      pending_decodes.delete();
    end else begin
      if (in_valid_i && !in_stall_i) absorb_byte(rx_byte_i);
      if (out_valid_i && !out_stall_i) check_result();
    end
    fail_count_o = fail_count;
    pending_o    = pending_decodes.size();
  end

endmodule

### bench/sync_length_frame_receiver_decoder_top_tb.sv
// Testbench top for sync_length_frame_receiver_decoder_top: feeds directed and random framed
// byte streams with bursty input and patterned output stalls, and reports the verdict.
// Depends on slfrd_pkg, the block and sync_length_frame_receiver_decoder_checker.
`timescale 1ns / 1ps
module sync_length_frame_receiver_decoder_top_tb;
  import slfrd_pkg::*;

  localparam int unsigned BUFFER_BYTES = 128;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned TAIL_CYCLES  = 100;
  localparam int unsigned HOLD_CYCLES  = 400;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  logic [7:0]         rx_byte_i   = 8'h00;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [1:0]         kind_o;
  logic [3:0]         item_index_o;
  logic [15:0]        analog_value_o;
  logic signed [31:0] motor_position_o;
  logic signed [15:0] motor_current_o;
  logic               last_o;

  int          fail_count;
  int          pending;
  int unsigned burst_left = 0;
  int unsigned bytes_sent = 0;
  int unsigned cycle_count = 0;
  logic        hold_go   = 1'b0;
  logic        hold_done = 1'b0;

  // short frames: analog low bank, motor, and an unknown method on the analog module
  logic [7:0] opening_bytes [24] = '{
    SYNC_FIRST, SYNC_SECOND, FRAME_ID, 8'h00, MOD_ANALOG, METH_LOW, 8'hFF, 8'h00,
    SYNC_FIRST, SYNC_SECOND, FRAME_ID, 8'h00, MOD_MOTOR, 8'h80, 8'hFF, 8'h7F,
    SYNC_FIRST, SYNC_SECOND, FRAME_ID, 8'h00, MOD_ANALOG, 8'h62, 8'h01, 8'hFE
  };

  sync_length_frame_receiver_decoder_top #(.BUFFER_BYTES(BUFFER_BYTES)) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .rx_byte_i       (rx_byte_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .kind_o          (kind_o),
    .item_index_o    (item_index_o),
    .analog_value_o  (analog_value_o),
    .motor_position_o(motor_position_o),
    .motor_current_o (motor_current_o),
    .last_o          (last_o)
  );

  sync_length_frame_receiver_decoder_checker #(.BUFFER_BYTES(BUFFER_BYTES)) frame_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .rx_byte_i       (rx_byte_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .kind_i          (kind_o),
    .item_index_i    (item_index_o),
    .analog_value_i  (analog_value_o),
    .motor_position_i(motor_position_o),
    .motor_current_i (motor_current_o),
    .last_i          (last_o),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Offers one byte and returns after the transaction; gaps only fall between bursts.
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 16);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    burst_left--;
    bytes_sent++;
  endtask

  // Drop valid and wait for every predicted result to be delivered.
  task automatic settle_outputs();
    in_valid_i <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    wait (pending == 0);
    @(posedge clk_i);
  endtask

  // shape 0: ordinary length, 1: frame exactly fills the buffer, 2: overflowing length
  task automatic send_frame(input int unsigned shape);
    int unsigned n;
    int unsigned pos;
    int unsigned body;
    int unsigned r;
    logic        pair_in_body;
    logic [7:0]  id_b;
    logic [7:0]  len_b;
    logic [7:0]  mod_b;
    logic [7:0]  meth_b;
    logic [7:0]  d;
    // line noise, sometimes a dangling first sync byte
    n = $urandom_range(0, 3);
    repeat (n) send_byte(($urandom_range(0, 3) == 0) ? SYNC_FIRST : 8'($urandom_range(0, 255)));
    id_b = ($urandom_range(0, 4) != 0) ? FRAME_ID : 8'($urandom_range(0, 255));
    r = $urandom_range(0, 9);
    mod_b = (r < 4) ? MOD_ANALOG : (r < 8) ? MOD_MOTOR : 8'($urandom_range(0, 255));
    if ($urandom_range(0, 5) != 0)
      meth_b = $urandom_range(0, 1) ? METH_HIGH : METH_LOW;
    else
      meth_b = 8'($urandom_range(0, 255));
    case (shape)
      1: len_b = 8'(BUFFER_BYTES - LEN_EXTRA);
      2: len_b = 8'($urandom_range(BUFFER_BYTES - LEN_EXTRA + 1, 255));
      default: len_b = ($urandom_range(0, 5) == 0) ? 8'($urandom_range(0, 22))
                                                   : 8'($urandom_range(23, 30));
    endcase
    pair_in_body = ($urandom_range(0, 3) == 0);
    send_byte(SYNC_FIRST);
    send_byte(SYNC_SECOND);
    send_byte(id_b);
    send_byte(len_b);
    send_byte(mod_b);
    send_byte(meth_b);
    body = len_b + LEN_EXTRA;
    if (body > BUFFER_BYTES) body = BUFFER_BYTES;
    for (pos = 6; pos < body; pos++) begin
      r = $urandom_range(0, 7);
      d = (r == 0) ? 8'h00 : (r == 1) ? 8'hFF : 8'($urandom_range(0, 255));
      // a sync pair inside a frame is plain data
      if (pair_in_body && pos == 9) d = SYNC_FIRST;
      if (pair_in_body && pos == 10) d = SYNC_SECOND;
      send_byte(d);
    end
  endtask

  // Output side: stall pattern segments, plus one long hold-off once requested.
  initial begin : out_pacer
    int unsigned mode;
    int unsigned span;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_go && !hold_done) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_done = 1'b1;
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(5, 60);
      repeat (span) begin
        case (mode)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= ($urandom_range(0, 3) == 0);
          2: out_stall_i <= $urandom_range(0, 1);
          default: out_stall_i <= ($urandom_range(0, 3) != 0);
        endcase
        @(posedge clk_i);
      end
    end
  end

  initial begin : stimulus
    int unsigned frame_no;
    int unsigned shape;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (opening_bytes[j]) send_byte(opening_bytes[j]);
    settle_outputs();
    hold_go = 1'b1;
    frame_no = 0;
    while (bytes_sent < 100) begin
      shape = 0;
      if (frame_no == 1) shape = 1;
      else if ($urandom_range(0, 19) == 0) shape = $urandom_range(1, 2);
      send_frame(shape);
      frame_no++;
    end
    settle_outputs();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
